// File: sv/obb_pkg.sv
package obb_pkg;

	localparam int W_IN   = 32;
	localparam int W_DIFF = 33;
	localparam int W_PROD = 66;
	localparam int W_AD   = 65;
	localparam int W_R    = 65;
	localparam int W_SUM  = 66;
	localparam int W_NSQ  = 64;
	localparam int W_LEN  = 32;
	localparam int W_PEN  = 31;
	localparam int W_NRM  = 16;

	localparam int NUM_AXES = 4;

	localparam int SQ_STEPS  = 2;
	localparam int SQ_BITS   = 32;
	localparam int LAT_SQRT  = SQ_BITS / SQ_STEPS;
	localparam int DIV_STEPS = 4;
	localparam int PEN_QW    = 31;
	localparam int NRM_QW    = 15;
	localparam int LAT_PDIV  = (PEN_QW + DIV_STEPS - 1) / DIV_STEPS;
	localparam int LAT_NDIV  = (NRM_QW + DIV_STEPS - 1) / DIV_STEPS;
	localparam int LAT_AXIS  = 2 + LAT_SQRT + LAT_PDIV;

	localparam logic [W_PEN-1:0] PEN_MAX = '1;

	typedef struct packed {
		logic signed [W_IN-1:0] x;
		logic signed [W_IN-1:0] y;
	} vec_t;

	typedef struct packed {
		logic                     sep;
		logic                     flip;
		logic signed [W_DIFF-1:0] nx;
		logic signed [W_DIFF-1:0] ny;
		logic [W_LEN-1:0]         len;
		logic [W_PEN-1:0]         pen;
	} axis_res_t;

	typedef struct packed {
		logic                    coll;
		logic signed [W_NRM-1:0] nx;
		logic signed [W_NRM-1:0] ny;
		logic [W_PEN-1:0]        pen;
	} result_t;

	function automatic logic signed [W_DIFF-1:0] sext(input logic signed [W_IN-1:0] v);
		return {v[W_IN-1], v};
	endfunction

	function automatic logic signed [W_PROD-1:0] smul(input logic signed [W_DIFF-1:0] a,
		input logic signed [W_DIFF-1:0] b);
		logic signed [W_PROD-1:0] r;
		r = a * b;
		return r;
	endfunction

	function automatic logic [W_PROD-1:0] mag(input logic signed [W_PROD-1:0] v);
		return v[W_PROD-1] ? -v : v;
	endfunction

endpackage

// File: sv/obb_pair_sat_collision.sv
// Separating-axis overlap test for two oriented boxes, one pair per item, no state kept
// between pairs. A new item is taken every cycle while the output buffer has room; the
// pipeline depth is set by the 16-stage integer square root of each axis length, the
// 8-stage penetration divider and the 4-stage normal dividers. A two-entry output
// buffer holds finished results; the pipeline only stalls when both entries are full.
module obb_pair_sat_collision (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic signed [obb_pkg::W_IN-1:0]   a_center_x,
	input  logic signed [obb_pkg::W_IN-1:0]   a_center_y,
	input  logic signed [obb_pkg::W_IN-1:0]   a_axis_u_x,
	input  logic signed [obb_pkg::W_IN-1:0]   a_axis_u_y,
	input  logic signed [obb_pkg::W_IN-1:0]   a_axis_v_x,
	input  logic signed [obb_pkg::W_IN-1:0]   a_axis_v_y,
	input  logic signed [obb_pkg::W_IN-1:0]   b_center_x,
	input  logic signed [obb_pkg::W_IN-1:0]   b_center_y,
	input  logic signed [obb_pkg::W_IN-1:0]   b_axis_u_x,
	input  logic signed [obb_pkg::W_IN-1:0]   b_axis_u_y,
	input  logic signed [obb_pkg::W_IN-1:0]   b_axis_v_x,
	input  logic signed [obb_pkg::W_IN-1:0]   b_axis_v_y,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic                              colliding,
	output logic signed [obb_pkg::W_NRM-1:0]  normal_x,
	output logic signed [obb_pkg::W_NRM-1:0]  normal_y,
	output logic [obb_pkg::W_PEN-1:0]         penetration
);

	localparam int NA      = obb_pkg::NUM_AXES;
	localparam int WD      = obb_pkg::W_DIFF;
	localparam int WLEN    = obb_pkg::W_LEN;
	localparam int WPEN    = obb_pkg::W_PEN;
	localparam int WNRM    = obb_pkg::W_NRM;
	localparam int NQW     = obb_pkg::NRM_QW;
	localparam int LND     = obb_pkg::LAT_NDIV;
	localparam int LAT_TOT = obb_pkg::LAT_AXIS + LND + 2;

	logic       en;
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic [LAT_TOT-1:0] vld_q;

	assign en        = cnt_q != 2'd2;
	assign req_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT_TOT-2:0], req_valid};
		end
	end

	logic signed [WD-1:0] dx_s1, dy_s1;
	obb_pkg::vec_t [NA-1:0] box_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1     <= obb_pkg::sext(b_center_x) - obb_pkg::sext(a_center_x);
			dy_s1     <= obb_pkg::sext(b_center_y) - obb_pkg::sext(a_center_y);
			box_s1[0] <= '{x: a_axis_u_x, y: a_axis_u_y};
			box_s1[1] <= '{x: a_axis_v_x, y: a_axis_v_y};
			box_s1[2] <= '{x: b_axis_u_x, y: b_axis_u_y};
			box_s1[3] <= '{x: b_axis_v_x, y: b_axis_v_y};
		end
	end

	obb_pkg::axis_res_t ax_res [NA];

	genvar k;
	for (k = 0; k < NA; k++) begin : g_axis
		obb_axis u_axis (
			.clk      (clk),
			.en       (en),
			.dx       (dx_s1),
			.dy       (dy_s1),
			.axis_vec (box_s1[k]),
			.box_vec  (box_s1),
			.res      (ax_res[k])
		);
	end

	obb_pkg::axis_res_t best_c;
	logic               any_sep_c;
	logic [WD-1:0]      mx_c, my_c;

	always_comb begin
		best_c    = ax_res[0];
		any_sep_c = ax_res[0].sep;
		for (int i = 1; i < NA; i++) begin
			any_sep_c = any_sep_c | ax_res[i].sep;
			if (ax_res[i].pen < best_c.pen)
				best_c = ax_res[i];
		end
	end

	assign mx_c = best_c.nx[WD-1] ? -best_c.nx : best_c.nx;
	assign my_c = best_c.ny[WD-1] ? -best_c.ny : best_c.ny;

	logic            coll_q, negx_q, negy_q;
	logic [WPEN-1:0] pen_q;
	logic [WLEN-1:0] magx_q, magy_q, len_q;

	always_ff @(posedge clk) begin
		if (en) begin
			coll_q <= !any_sep_c;
			negx_q <= best_c.nx[WD-1] ^ best_c.flip;
			negy_q <= best_c.ny[WD-1] ^ best_c.flip;
			pen_q  <= best_c.pen;
			magx_q <= mx_c[WLEN-1:0];
			magy_q <= my_c[WLEN-1:0];
			len_q  <= best_c.len;
		end
	end

	logic [NQW-1:0] qx_c, qy_c;

	obb_div #(
		.QW (NQW)
	) u_nx_div (
		.clk    (clk),
		.en     (en),
		.rem_in ({1'b0, magx_q[WLEN-1:1]}),
		.low_in ({magx_q[0], {(NQW-1){1'b0}}}),
		.den    (len_q),
		.quo    (qx_c)
	);

	obb_div #(
		.QW (NQW)
	) u_ny_div (
		.clk    (clk),
		.en     (en),
		.rem_in ({1'b0, magy_q[WLEN-1:1]}),
		.low_in ({magy_q[0], {(NQW-1){1'b0}}}),
		.den    (len_q),
		.quo    (qy_c)
	);

	logic            coll_d_q [LND];
	logic            negx_d_q [LND];
	logic            negy_d_q [LND];
	logic [WPEN-1:0] pen_d_q  [LND];

	always_ff @(posedge clk) begin
		if (en) begin
			coll_d_q[0] <= coll_q;
			negx_d_q[0] <= negx_q;
			negy_d_q[0] <= negy_q;
			pen_d_q[0]  <= pen_q;
			for (int i = 1; i < LND; i++) begin
				coll_d_q[i] <= coll_d_q[i-1];
				negx_d_q[i] <= negx_d_q[i-1];
				negy_d_q[i] <= negy_d_q[i-1];
				pen_d_q[i]  <= pen_d_q[i-1];
			end
		end
	end

	logic [WNRM-1:0]  ux_c, uy_c;
	obb_pkg::result_t res_c;

	assign ux_c = WNRM'(qx_c);
	assign uy_c = WNRM'(qy_c);

	always_comb begin
		res_c = '0;
		if (coll_d_q[LND-1]) begin
			res_c.coll = 1'b1;
			res_c.nx   = negx_d_q[LND-1] ? -ux_c : ux_c;
			res_c.ny   = negy_d_q[LND-1] ? -uy_c : uy_c;
			res_c.pen  = pen_d_q[LND-1];
		end
	end

	obb_pkg::result_t fifo_q [2];
	logic push, pop;

	assign push = en && vld_q[LAT_TOT-1];
	assign pop  = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_q] <= res_c;
	end

	assign rsp_valid   = cnt_q != 2'd0;
	assign colliding   = fifo_q[rd_q].coll;
	assign normal_x    = fifo_q[rd_q].nx;
	assign normal_y    = fifo_q[rd_q].ny;
	assign penetration = fifo_q[rd_q].pen;

	a_zero_when_apart: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !colliding |-> normal_x == '0 && normal_y == '0 && penetration == '0)
		else $error("separated pair carries a nonzero normal or depth");

	a_normal_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && colliding |-> normal_x != '0 || normal_y != '0)
		else $error("colliding pair has a zero normal");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");

endmodule

// File: sv/obb_div.sv
module obb_div #(
	parameter int QW = obb_pkg::PEN_QW
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [obb_pkg::W_LEN-1:0] rem_in,
	input  logic [QW-1:0]             low_in,
	input  logic [obb_pkg::W_LEN-1:0] den,
	output logic [QW-1:0]             quo
);

	localparam int DW    = obb_pkg::W_LEN;
	localparam int STEPS = obb_pkg::DIV_STEPS;
	localparam int NST   = (QW + STEPS - 1) / STEPS;

	logic [DW-1:0] r_q [NST];
	logic [QW-1:0] l_q [NST];
	logic [QW-1:0] q_q [NST];
	logic [DW-1:0] d_q [NST];

	logic [DW-1:0] r_in [NST];
	logic [QW-1:0] l_in [NST];
	logic [QW-1:0] q_in [NST];
	logic [DW-1:0] d_in [NST];

	genvar g;
	for (g = 0; g < NST; g++) begin : g_stage
		logic [DW-1:0] r_c;
		logic [QW-1:0] l_c;
		logic [QW-1:0] q_c;

		if (g == 0) begin : g_head
			assign r_in[g] = rem_in;
			assign l_in[g] = low_in;
			assign q_in[g] = '0;
			assign d_in[g] = den;
		end else begin : g_body
			assign r_in[g] = r_q[g-1];
			assign l_in[g] = l_q[g-1];
			assign q_in[g] = q_q[g-1];
			assign d_in[g] = d_q[g-1];
		end

		always_comb begin : p_step
			logic [DW:0]   t;
			logic [DW-1:0] r;
			logic [QW-1:0] l;
			logic [QW-1:0] q;
			r = r_in[g];
			l = l_in[g];
			q = q_in[g];
			t = '0;
			for (int i = 0; i < STEPS; i++) begin
				if (g * STEPS + i < QW) begin
					t = {r, l[QW-1]};
					l = l << 1;
					q = q << 1;
					if (t >= {1'b0, d_in[g]}) begin
						t = t - {1'b0, d_in[g]};
						q[0] = 1'b1;
					end
					r = t[DW-1:0];
				end
			end
			r_c = r;
			l_c = l;
			q_c = q;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[g] <= r_c;
				l_q[g] <= l_c;
				q_q[g] <= q_c;
				d_q[g] <= d_in[g];
			end
		end
	end

	assign quo = q_q[NST-1];

endmodule

// File: sv/obb_isqrt.sv
module obb_isqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [obb_pkg::W_NSQ-1:0] rad,
	output logic [obb_pkg::W_LEN-1:0] root
);

	localparam int RW    = obb_pkg::W_NSQ;
	localparam int STEPS = obb_pkg::SQ_STEPS;
	localparam int NST   = obb_pkg::LAT_SQRT;

	logic [RW-1:0] n_q  [NST];
	logic [RW-1:0] r_q  [NST];
	logic [RW-1:0] n_in [NST];
	logic [RW-1:0] r_in [NST];

	genvar g;
	for (g = 0; g < NST; g++) begin : g_stage
		logic [RW-1:0] n_c;
		logic [RW-1:0] r_c;

		if (g == 0) begin : g_head
			assign n_in[g] = rad;
			assign r_in[g] = '0;
		end else begin : g_body
			assign n_in[g] = n_q[g-1];
			assign r_in[g] = r_q[g-1];
		end

		always_comb begin : p_step
			logic [RW-1:0] n;
			logic [RW-1:0] r;
			logic [RW-1:0] b;
			n = n_in[g];
			r = r_in[g];
			b = '0;
			for (int i = 0; i < STEPS; i++) begin
				b = RW'(1) << (RW - 2 - 2 * (g * STEPS + i));
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
			end
			n_c = n;
			r_c = r;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_q[g] <= n_c;
				r_q[g] <= r_c;
			end
		end
	end

	assign root = r_q[NST-1][obb_pkg::W_LEN-1:0];

endmodule

// File: sv/obb_axis.sv
module obb_axis (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [obb_pkg::W_DIFF-1:0] dx,
	input  logic signed [obb_pkg::W_DIFF-1:0] dy,
	input  obb_pkg::vec_t                     axis_vec,
	input  obb_pkg::vec_t [obb_pkg::NUM_AXES-1:0] box_vec,
	output obb_pkg::axis_res_t                res
);

	localparam int NA        = obb_pkg::NUM_AXES;
	localparam int WD        = obb_pkg::W_DIFF;
	localparam int WP        = obb_pkg::W_PROD;
	localparam int WSUM      = obb_pkg::W_SUM;
	localparam int WPEN      = obb_pkg::W_PEN;
	localparam int WLEN      = obb_pkg::W_LEN;
	localparam int WHI       = WSUM - WPEN;
	localparam int LPD       = obb_pkg::LAT_PDIV;
	localparam int DLY_DEPTH = obb_pkg::LAT_SQRT - 3;
	localparam int DLY_SIDE  = DLY_DEPTH + LPD;

	logic signed [WD-1:0] nx_c, ny_c;
	logic signed [WP-1:0] sqx_c, sqy_c;

	assign nx_c  = -obb_pkg::sext(axis_vec.y);
	assign ny_c  = obb_pkg::sext(axis_vec.x);
	assign sqx_c = obb_pkg::smul(nx_c, nx_c);
	assign sqy_c = obb_pkg::smul(ny_c, ny_c);

	logic signed [WD-1:0] nx_s1, ny_s1;
	logic signed [WP-1:0] pdx_s1, pdy_s1;
	logic signed [WP-1:0] pwx_s1 [NA];
	logic signed [WP-1:0] pwy_s1 [NA];
	logic [obb_pkg::W_NSQ-1:0] qx_s1, qy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1  <= nx_c;
			ny_s1  <= ny_c;
			pdx_s1 <= obb_pkg::smul(dx, nx_c);
			pdy_s1 <= obb_pkg::smul(dy, ny_c);
			qx_s1  <= sqx_c[obb_pkg::W_NSQ-1:0];
			qy_s1  <= sqy_c[obb_pkg::W_NSQ-1:0];
			for (int k = 0; k < NA; k++) begin
				pwx_s1[k] <= obb_pkg::smul(obb_pkg::sext(box_vec[k].x), nx_c);
				pwy_s1[k] <= obb_pkg::smul(obb_pkg::sext(box_vec[k].y), ny_c);
			end
		end
	end

	logic signed [WD-1:0] nx_s2, ny_s2;
	logic signed [WP-1:0] d_s2;
	logic signed [WP-1:0] dot_s2 [NA];
	logic [obb_pkg::W_NSQ-1:0] nsq_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			d_s2   <= pdx_s1 + pdy_s1;
			nsq_s2 <= qx_s1 + qy_s1;
			for (int k = 0; k < NA; k++)
				dot_s2[k] <= pwx_s1[k] + pwy_s1[k];
		end
	end

	logic [WP-1:0] ad_c, ra_c, rb_c;
	assign ad_c = obb_pkg::mag(d_s2);
	assign ra_c = obb_pkg::mag(dot_s2[0]) + obb_pkg::mag(dot_s2[1]);
	assign rb_c = obb_pkg::mag(dot_s2[2]) + obb_pkg::mag(dot_s2[3]);

	logic signed [WD-1:0] nx_s3, ny_s3;
	logic flip_s3;
	logic [obb_pkg::W_AD-1:0] ad_s3;
	logic [obb_pkg::W_R-1:0] ra_s3, rb_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3   <= nx_s2;
			ny_s3   <= ny_s2;
			flip_s3 <= d_s2[WP-1];
			ad_s3   <= ad_c[obb_pkg::W_AD-1:0];
			ra_s3   <= ra_c[obb_pkg::W_R-1:0];
			rb_s3   <= rb_c[obb_pkg::W_R-1:0];
		end
	end

	logic signed [WD-1:0] nx_s4, ny_s4;
	logic flip_s4;
	logic [obb_pkg::W_AD-1:0] ad_s4;
	logic [WSUM-1:0] sum_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s4   <= nx_s3;
			ny_s4   <= ny_s3;
			flip_s4 <= flip_s3;
			ad_s4   <= ad_s3;
			sum_s4  <= {1'b0, ra_s3} + {1'b0, rb_s3};
		end
	end

	logic signed [WD-1:0] nx_s5, ny_s5;
	logic flip_s5, sep_s5;
	logic [WSUM-1:0] depth_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s5    <= nx_s4;
			ny_s5    <= ny_s4;
			flip_s5  <= flip_s4;
			sep_s5   <= {1'b0, ad_s4} >= sum_s4;
			depth_s5 <= sum_s4 - {1'b0, ad_s4};
		end
	end

	logic [WLEN-1:0] len_c;

	obb_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (nsq_s2),
		.root (len_c)
	);

	logic [WSUM-1:0] depth_q [DLY_DEPTH];
	logic [WD-1:0]   nx_q    [DLY_SIDE];
	logic [WD-1:0]   ny_q    [DLY_SIDE];
	logic            flip_q  [DLY_SIDE];
	logic            sep_q   [DLY_SIDE];
	logic [WLEN-1:0] len_q   [LPD];
	logic            sat_q   [LPD];

	logic [WSUM-1:0] depth_d;
	logic            sat_c;
	logic [WPEN-1:0] quo_c;

	assign depth_d = depth_q[DLY_DEPTH-1];
	assign sat_c   = depth_d[WSUM-1:WPEN] >= WHI'(len_c);

	always_ff @(posedge clk) begin
		if (en) begin
			depth_q[0] <= depth_s5;
			for (int i = 1; i < DLY_DEPTH; i++)
				depth_q[i] <= depth_q[i-1];
			nx_q[0]   <= nx_s5;
			ny_q[0]   <= ny_s5;
			flip_q[0] <= flip_s5;
			sep_q[0]  <= sep_s5;
			for (int i = 1; i < DLY_SIDE; i++) begin
				nx_q[i]   <= nx_q[i-1];
				ny_q[i]   <= ny_q[i-1];
				flip_q[i] <= flip_q[i-1];
				sep_q[i]  <= sep_q[i-1];
			end
			len_q[0] <= len_c;
			sat_q[0] <= sat_c;
			for (int i = 1; i < LPD; i++) begin
				len_q[i] <= len_q[i-1];
				sat_q[i] <= sat_q[i-1];
			end
		end
	end

	obb_div #(
		.QW (obb_pkg::PEN_QW)
	) u_pen_div (
		.clk    (clk),
		.en     (en),
		.rem_in (depth_d[WPEN+WLEN-1:WPEN]),
		.low_in (depth_d[WPEN-1:0]),
		.den    (len_c),
		.quo    (quo_c)
	);

	assign res.sep  = sep_q[DLY_SIDE-1];
	assign res.flip = flip_q[DLY_SIDE-1];
	assign res.nx   = nx_q[DLY_SIDE-1];
	assign res.ny   = ny_q[DLY_SIDE-1];
	assign res.len  = len_q[LPD-1];
	assign res.pen  = sat_q[LPD-1] ? obb_pkg::PEN_MAX : quo_c;

endmodule
